FILE: rtl/core/ism_pkg.sv
package ism_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 32;
    localparam int OP_W        = 4;
    localparam int DEPTH_W     = 7;
    localparam int STATUS_W    = 3;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W       = $clog2(WORD_W);

    // stream payload layout
    localparam int IN_DATA_W   = ((OP_W + WORD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = WORD_W + DEPTH_W + STATUS_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_CONST = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MAX   = 4'd5,
        OP_MIN   = 4'd6,
        OP_NEG   = 4'd7,
        OP_DUP   = 4'd8,
        OP_SWAP  = 4'd9
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_OVER    = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    // what a stack cell does on the next edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_LOAD
    } t_cell_op;

endpackage

FILE: rtl/core/integer_stack_machine_unit.sv
// channel  | dir | handshake                | tdata fields, lowest bit up
// ---------+-----+--------------------------+-------------------------------------------
// s (in)   | in  | i_s_tvalid / o_s_tready  | opcode[3:0], immediate[35:4], zero [39:36]
// m (out)  | out | o_m_tvalid / i_m_tready  | top_value[31:0], stack_depth[38:32],
//          |     |                          | status[41:39], zero [47:42]
//
// one instruction at a time: each transaction is accepted, then executed; MUL
// adds a step for the registered product, and DIV waits on the restoring divider
// (one quotient bit per cycle)
// the stack is a row of word cells that shift towards or away from the top
// i_rst_n is synchronous: empties the stack and drops any pending result
// a stalled result sits in the output register; the next transaction is still
// taken in, and its result commits only once that register is free
module integer_stack_machine_unit
    import ism_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // opcode, immediate
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // top_value, stack_depth, status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MULW,
        S_DIVW
    } t_state;

    t_state r_state, n_state;

    // captured instruction
    logic [OP_W-1:0]   r_op, n_op;
    logic [WORD_W-1:0] r_imm, n_imm;

    logic [SP_W-1:0]   r_sp, n_sp;
    logic [WORD_W-1:0] r_prod, n_prod;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [WORD_W-1:0]   r_out_top, n_out_top;
    logic [DEPTH_W-1:0]  r_out_depth, n_out_depth;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    // stack cells, index 0 is the top
    logic [WORD_W-1:0] words [STACK_DEPTH];
    logic [WORD_W-1:0] a_word, b_word;

    t_cell_op ctl_top, ctl_second, ctl_rest;
    logic [WORD_W-1:0] load_top;

    t_status status_c;
    logic    long_op;
    logic    ok;
    logic    out_free;
    logic    apply;
    logic    full;

    logic              div_start;
    logic              div_busy;
    logic [WORD_W-1:0] div_q;
    logic [WORD_W-1:0] bin_res;

    assign a_word   = words[0];
    assign b_word   = words[1];
    assign full     = (r_sp == SP_W'(STACK_DEPTH));
    assign out_free = !r_out_valid || i_m_tready;

    // status check against the current stack, before anything moves
    always_comb begin
        status_c = ST_OK;
        long_op  = 1'b0;
        unique case (r_op) inside
            OP_CONST: begin
                if (full) status_c = ST_OVER;
            end
            OP_NEG: begin
                if (r_sp == '0) status_c = ST_UNDER;
            end
            OP_DUP: begin
                if (r_sp == '0) status_c = ST_UNDER;
                else if (full) status_c = ST_OVER;
            end
            OP_ADD, OP_SUB, OP_MAX, OP_MIN, OP_SWAP: begin
                if (r_sp < SP_W'(2)) status_c = ST_UNDER;
            end
            OP_MUL: begin
                if (r_sp < SP_W'(2)) status_c = ST_UNDER;
                else long_op = 1'b1;
            end
            OP_DIV: begin
                if (r_sp < SP_W'(2)) status_c = ST_UNDER;
                else if (b_word == '0) status_c = ST_DIVZERO;
                else long_op = 1'b1;
            end
            default: status_c = ST_UNKNOWN;
        endcase
    end

    assign ok = (status_c == ST_OK);

    // result of the two-operand ops, a is the top and b the next word
    always_comb begin
        case (r_op)
            OP_ADD:  bin_res = a_word + b_word;
            OP_SUB:  bin_res = a_word - b_word;
            OP_MUL:  bin_res = r_prod;
            OP_DIV:  bin_res = div_q;
            OP_MAX:  bin_res = ($signed(a_word) > $signed(b_word)) ? a_word : b_word;
            OP_MIN:  bin_res = ($signed(b_word) > $signed(a_word)) ? a_word : b_word;
            default: bin_res = a_word;
        endcase
    end

    // the step commits once its result can go straight into the output register
    assign apply = out_free &&
                   ((r_state == S_EXEC && !long_op) ||
                    (r_state == S_MULW) ||
                    (r_state == S_DIVW && !div_busy));

    assign div_start = (r_state == S_EXEC) && long_op && (r_op == OP_DIV);

    // cell commands and the new top word
    always_comb begin
        ctl_top    = CELL_HOLD;
        ctl_second = CELL_HOLD;
        ctl_rest   = CELL_HOLD;
        n_sp       = r_sp;
        case (r_op)
            OP_CONST: load_top = r_imm;
            OP_DUP:   load_top = a_word;
            OP_NEG:   load_top = '0 - a_word;
            OP_SWAP:  load_top = b_word;
            default:  load_top = bin_res;
        endcase
        if (apply && ok) begin
            ctl_top = CELL_LOAD;
            case (r_op)
                OP_CONST, OP_DUP: begin
                    ctl_second = CELL_PUSH;
                    ctl_rest   = CELL_PUSH;
                    n_sp       = r_sp + 1'b1;
                end
                OP_NEG: begin
                end
                OP_SWAP: begin
                    ctl_second = CELL_LOAD;
                end
                default: begin
                    // two words in, one out
                    ctl_second = CELL_POP;
                    ctl_rest   = CELL_POP;
                    n_sp       = r_sp - 1'b1;
                end
            endcase
        end
    end

    // row of cells
    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        logic [WORD_W-1:0] from_prev;
        logic [WORD_W-1:0] from_next;
        logic [WORD_W-1:0] load_val;
        t_cell_op          cell_op;

        if (gi == 0) begin : g_top
            assign from_prev = '0;
            assign load_val  = load_top;
            assign cell_op   = ctl_top;
        end else if (gi == 1) begin : g_second
            assign from_prev = words[gi-1];
            assign load_val  = words[0];
            assign cell_op   = ctl_second;
        end else begin : g_body
            assign from_prev = words[gi-1];
            assign load_val  = '0;
            assign cell_op   = ctl_rest;
        end

        if (gi == STACK_DEPTH - 1) begin : g_bottom
            assign from_next = '0;
        end else begin : g_inner
            assign from_next = words[gi+1];
        end

        ism_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (cell_op),
            .i_from_prev (from_prev),
            .i_from_next (from_next),
            .i_load      (load_val),
            .o_word      (words[gi])
        );
    end

    ism_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (a_word),
        .i_divisor  (b_word),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    // sequencing and output register
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_imm        = r_imm;
        n_prod       = r_prod;
        n_out_valid  = r_out_valid;
        n_out_top    = r_out_top;
        n_out_depth  = r_out_depth;
        n_out_status = r_out_status;

        if (r_out_valid && i_m_tready) n_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op    = i_s_tdata[OP_W-1:0];
                    n_imm   = i_s_tdata[OP_W +: WORD_W];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (long_op) begin
                    if (r_op == OP_MUL) begin
                        n_prod  = a_word * b_word;
                        n_state = S_MULW;
                    end else begin
                        n_state = S_DIVW;
                    end
                end else if (apply) begin
                    n_state = S_IDLE;
                end
            end
            S_MULW, S_DIVW: begin
                if (apply) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (apply) begin
            n_out_valid  = 1'b1;
            n_out_depth  = DEPTH_W'(n_sp);
            n_out_status = status_c;
            if (ok) n_out_top = load_top;
            else if (r_sp != '0) n_out_top = a_word;
            else n_out_top = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_imm        <= n_imm;
        r_prod       <= n_prod;
        r_out_top    <= n_out_top;
        r_out_depth  <= n_out_depth;
        r_out_status <= n_out_status;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - OUT_FIELD_W)'(0), r_out_status, r_out_depth, r_out_top};

endmodule

FILE: rtl/core/ism_cell.sv
module ism_cell
    import ism_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_op          i_op,
    input  logic [WORD_W-1:0] i_from_prev,
    input  logic [WORD_W-1:0] i_from_next,
    input  logic [WORD_W-1:0] i_load,
    output logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        case (i_op)
            CELL_PUSH: n_word = i_from_prev;
            CELL_POP:  n_word = i_from_next;
            CELL_LOAD: n_word = i_load;
            default:   n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

FILE: rtl/core/ism_div.sv
module ism_div
    import ism_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_dividend,
    input  logic [WORD_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [WORD_W-1:0] o_quotient
);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_q;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_div;
    logic              r_neg;

    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   diff;

    // restoring step, one quotient bit per cycle
    assign rem_sh = {r_rem, r_q[WORD_W-1]};
    assign diff   = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(WORD_W - 1);
            r_q   <= i_dividend[WORD_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_div <= i_divisor[WORD_W-1] ? (~i_divisor + 1'b1) : i_divisor;
            r_rem <= '0;
            r_neg <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (!diff[WORD_W]) begin
                r_rem <= diff[WORD_W-1:0];
                r_q   <= {r_q[WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[WORD_W-1:0];
                r_q   <= {r_q[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? (~r_q + 1'b1) : r_q;

endmodule

FILE: rtl/core/ism_checker.sv
module ism_checker
    import ism_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata
);

    logic [WORD_W-1:0]   top_f;
    logic [DEPTH_W-1:0]  depth_f;
    logic [STATUS_W-1:0] status_f;

    assign top_f    = i_m_tdata[WORD_W-1:0];
    assign depth_f  = i_m_tdata[WORD_W +: DEPTH_W];
    assign status_f = i_m_tdata[WORD_W + DEPTH_W +: STATUS_W];

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("result changed while stalled");

    // one instruction in flight: input closes right after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("input ready right after a transaction");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (status_f == ST_OK || status_f == ST_UNDER ||
                        status_f == ST_OVER || status_f == ST_DIVZERO ||
                        status_f == ST_UNKNOWN))
        else $error("status code out of range");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (depth_f <= DEPTH_W'(STACK_DEPTH)))
        else $error("stack depth beyond capacity");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && depth_f == '0) |-> (top_f == '0))
        else $error("empty stack reports a non-zero top");

endmodule

bind integer_stack_machine_unit ism_checker u_ism_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

FILE: dv/stack_result_checker.sv
module stack_result_checker
    import ism_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // opcode, immediate
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,   // top_value, stack_depth, status
    output int                    o_fail_count,
    output int                    o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [WORD_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
        logic [STATUS_W-1:0] status;
    } t_step_result;

    // shadow copy of the stack, only entries below words_held are meaningful
    logic [WORD_W-1:0] stack_words [STACK_DEPTH];
    int unsigned       words_held = 0;
    t_step_result      predicted_steps [$];
    t_step_result      got_step;
    t_step_result      want_step;
    int                fail_tally = 0;

    // runs one instruction on the shadow stack and returns what the unit should report
    function automatic t_step_result execute_instr(logic [OP_W-1:0] opcode,
                                                   logic [WORD_W-1:0] imm);
        t_step_result       res;
        logic [WORD_W-1:0]  a;
        logic [WORD_W-1:0]  b;
        logic [WORD_W-1:0]  r;
        logic [WORD_W-1:0]  mag_a;
        logic [WORD_W-1:0]  mag_b;
        logic [WORD_W-1:0]  quot;
        logic               commit;
        t_status            st;

        st     = ST_OK;
        commit = 1'b0;
        r      = '0;
        if (opcode > OP_SWAP) begin
            st = ST_UNKNOWN;
        end else if (opcode == OP_CONST) begin
            if (words_held >= STACK_DEPTH) begin
                st = ST_OVER;
            end else begin
                stack_words[words_held] = imm;
                words_held++;
            end
        end else if (opcode == OP_NEG || opcode == OP_DUP) begin
            if (words_held < 1) begin
                st = ST_UNDER;
            end else if (opcode == OP_NEG) begin
                stack_words[words_held-1] = -stack_words[words_held-1];
            end else if (words_held >= STACK_DEPTH) begin
                st = ST_OVER;
            end else begin
                stack_words[words_held] = stack_words[words_held-1];
                words_held++;
            end
        end else if (words_held < 2) begin
            // underflow wins over divide by zero
            st = ST_UNDER;
        end else begin
            a      = stack_words[words_held-1];
            b      = stack_words[words_held-2];
            commit = 1'b1;
            case (opcode)
                OP_ADD: r = a + b;
                OP_SUB: r = a - b;
                OP_MUL: r = a * b;
                OP_DIV: begin
                    if (b == '0) begin
                        st     = ST_DIVZERO;
                        commit = 1'b0;
                    end else begin
                        // truncate toward zero on magnitudes, min / -1 wraps back to min
                        mag_a = a[WORD_W-1] ? -a : a;
                        mag_b = b[WORD_W-1] ? -b : b;
                        quot  = mag_a / mag_b;
                        r     = (a[WORD_W-1] != b[WORD_W-1]) ? -quot : quot;
                    end
                end
                OP_MAX: r = ($signed(a) > $signed(b)) ? a : b;
                OP_MIN: r = ($signed(b) > $signed(a)) ? a : b;
                default: begin
                    stack_words[words_held-2] = a;
                    stack_words[words_held-1] = b;
                    commit = 1'b0;
                end
            endcase
            if (commit) begin
                stack_words[words_held-2] = r;
                words_held--;
            end
        end

        res.top    = (words_held > 0) ? stack_words[words_held-1] : '0;
        res.depth  = DEPTH_W'(words_held);
        res.status = st;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            words_held = 0;
            predicted_steps.delete();
        end else begin
            // results first, an instruction taken at this edge cannot be answered yet
            if (i_m_tvalid && i_m_tready) begin
                got_step.top    = i_m_tdata[WORD_W-1:0];
                got_step.depth  = i_m_tdata[WORD_W +: DEPTH_W];
                got_step.status = i_m_tdata[WORD_W+DEPTH_W +: STATUS_W];
                if (predicted_steps.size() == 0) begin
                    $error("unexpected result transaction: top_value %0d, stack_depth %0d, status %0d",
                           $signed(got_step.top), got_step.depth, got_step.status);
                    fail_tally++;
                end else begin
                    want_step = predicted_steps.pop_front();
                    if (got_step.top !== want_step.top) begin
                        $error("top_value mismatch: expected %0d, actual %0d",
                               $signed(want_step.top), $signed(got_step.top));
                        fail_tally++;
                    end
                    if (got_step.depth !== want_step.depth) begin
                        $error("stack_depth mismatch: expected %0d, actual %0d",
                               want_step.depth, got_step.depth);
                        fail_tally++;
                    end
                    if (got_step.status !== want_step.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want_step.status, got_step.status);
                        fail_tally++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predicted_steps.push_back(execute_instr(i_s_tdata[OP_W-1:0],
                                                        i_s_tdata[OP_W +: WORD_W]));
            end
        end
        // published after the edge so the stimulus side sees settled values
        o_pending    <= predicted_steps.size();
        o_fail_count <= fail_tally;
    end

endmodule

FILE: dv/tb_integer_stack_machine_unit.sv
module tb_integer_stack_machine_unit
    import ism_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 100;
    localparam int FILL_ITEMS      = 70;    // enough pushes to run into a full stack
    localparam int QUIET_LIMIT     = 4000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES    = 64;    // covers the divider with room to spare
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_W'(OP_SWAP + 1);
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    int fail_count;
    int pending_results;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int idle_by_phase  [4] = '{0, 58, 0, 31};
    int stall_by_phase [4] = '{0, 0, 58, 31};

    integer_stack_machine_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    stack_result_checker u_result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always #5 i_clk = ~i_clk;

    // result side back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog on a stuck handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("integer_stack_machine_unit test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // operand mix leaning on the corners: tiny values for zero divisors, extremes for wrap
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return WORD_W'($urandom_range(0, 8)) - WORD_W'(4);
            1: return {1'b1, {(WORD_W-1){1'b0}}};
            2: return {1'b0, {(WORD_W-1){1'b1}}};
            3: return '1;
            4: return '0;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // one instruction transaction, with random idle cycles ahead of it
    task automatic send_instr(input logic [OP_W-1:0] opcode, input logic [WORD_W-1:0] imm);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_DATA_W'({imm, opcode});
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // hold off the instruction stream until every result is back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    task automatic random_burst(inout int sent);
        int              len;
        logic [OP_W-1:0] opcode;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                len = $urandom_range(1, 8);
                repeat (len) begin
                    opcode = ($urandom_range(0, 3) == 0) ? OP_DUP : OP_CONST;
                    send_instr(opcode, rand_word());
                end
            end
            4, 5, 6, 7, 8: begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    opcode = OP_W'($urandom_range(OP_ADD, OP_SWAP));
                    send_instr(opcode, rand_word());
                end
            end
            default: begin
                len    = 1;
                opcode = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
                send_instr(opcode, rand_word());
            end
        endcase
        sent += len;
    endtask

    initial begin
        int sent;
        int fill_len;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners on a fresh stack
        send_instr(OP_ADD,  '0);                // underflow on empty
        send_instr(OP_NEG,  '0);
        send_instr(OP_DUP,  '0);
        send_instr(OP_FIRST_UNUSED, '1);        // unknown opcode
        send_instr(OP_CONST, 32'h8000_0000);
        send_instr(OP_SWAP, '0);                // one word only
        send_instr(OP_NEG,  '0);                // negating the most negative word
        send_instr(OP_CONST, 32'hFFFF_FFFF);
        send_instr(OP_SWAP, '0);
        send_instr(OP_DIV,  '0);                // most negative over minus one
        send_instr(OP_CONST, 32'h0000_0000);
        send_instr(OP_CONST, 32'h0000_0007);
        send_instr(OP_DIV,  '0);                // divisor zero leaves stack alone
        send_instr(OP_SUB,  '0);
        send_instr(OP_MUL,  '0);                // product wraps
        send_instr(OP_CONST, 32'h7FFF_FFFF);
        send_instr(OP_MAX,  '0);
        send_instr(OP_CONST, 32'hFFFF_FFFB);
        send_instr(OP_MIN,  '0);
        send_instr(OP_DUP,  '0);
        send_instr(OP_LAST_UNUSED, 32'h5A5A_A5A5);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = idle_by_phase[phase];
            stall_pct = stall_by_phase[phase];
            sent      = 0;
            // fill past the top so both push kinds meet a full stack
            if (phase == 0 || phase == 3) begin
                fill_len = FILL_ITEMS;
                repeat (fill_len) begin
                    send_instr(($urandom_range(0, 4) == 0) ? OP_DUP : OP_CONST, rand_word());
                end
                sent += fill_len;
            end
            while (sent < ITEMS_PER_PHASE) begin
                random_burst(sent);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("integer_stack_machine_unit test passed");
        end else begin
            $display("integer_stack_machine_unit test failed");
        end
        $finish;
    end

endmodule
